>>> rtl/core/ialu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types and codes for the integer ALU with status flags.
// ----------------------------------------------------------------------------
package ialu_pkg;

   localparam int unsigned DATA_W = 64;

   typedef enum logic [3:0] {
      ACT_XOR  = 4'd0,
      ACT_AND  = 4'd1,
      ACT_ADD  = 4'd2,
      ACT_SUB  = 4'd3,
      ACT_CMP  = 4'd4,
      ACT_INC  = 4'd5,
      ACT_DEC  = 4'd6,
      ACT_NEG  = 4'd7,
      ACT_TEST = 4'd8,
      ACT_STC  = 4'd9
   } action_type;

   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_WORD = 2'd1,
      SIZE_LONG = 2'd2,
      SIZE_QUAD = 2'd3
   } size_type;

   // bit 0 CF, bit 1 OF, bit 2 SF, bit 3 ZF, bit 4 PF
   typedef struct packed {
      logic pf;
      logic zf;
      logic sf;
      logic of;
      logic cf;
   } flags_type;

   typedef struct packed {
      flags_type          flags;
      logic               write_back;
      logic [DATA_W-1:0]  result;
   } exec_out_type;

endpackage
`default_nettype wire

>>> rtl/core/integer_alu_with_status_flags.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_alu_with_status_flags
// Integer ALU (xor/and/add/sub/cmp/inc/dec/neg/test/stc) with CF/OF/SF/ZF/PF.
// ----------------------------------------------------------------------------
// Accepts one word per clock unless both stages are full and rsp_tready is low,
// and returns one result word per input: an input register, the single-pass
// datapath, then the result register. The five status flags live in one
// register updated when a result is loaded, so each operation sees the flags
// of the one before it; that loop through the flag register sets the rate.
// Reset clears all flags. The input stage keeps accepting while a result
// waits, until both stages are full.
// ----------------------------------------------------------------------------
module integer_alu_with_status_flags (
   input  var logic         clock,
   input  var logic         reset,
   input  var logic         req_tvalid,
   output     logic         req_tready,
   // [3:0] action, [5:4] size_code, [69:6] src_value, [133:70] dst_value,
   // [135:134] zero
   input  var logic [135:0] req_tdata,
   output     logic         rsp_tvalid,
   input  var logic         rsp_tready,
   // [63:0] result_value, [64] write_back, [65] carry_flag,
   // [66] overflow_flag, [67] sign_flag, [68] zero_flag, [69] parity_flag,
   // [71:70] zero
   output     logic [71:0]  rsp_tdata
);
   import ialu_pkg::*;

   logic         in_valid_ff;
   logic         in_valid_in;
   action_type   in_action_ff;
   size_type     in_size_ff;
   logic [63:0]  in_src_ff;
   logic [63:0]  in_dst_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   exec_out_type out_ff;
   flags_type    flags_ff;
   exec_out_type exec_out;
   logic         req_fire;
   logic         advance;
   logic         move;

   assign advance    = !out_valid_ff || rsp_tready;
   assign move       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (move ? 1'b0 : in_valid_ff);
   assign out_valid_in = move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   ialu_exec u_exec (
      .action    (in_action_ff),
      .size_code (in_size_ff),
      .src_value (in_src_ff),
      .dst_value (in_dst_ff),
      .flags_cur (flags_ff),
      .exec_out  (exec_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (move) begin
            flags_ff <= exec_out.flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff <= action_type'(req_tdata[3:0]);
         in_size_ff   <= size_type'(req_tdata[5:4]);
         in_src_ff    <= req_tdata[69:6];
         in_dst_ff    <= req_tdata[133:70];
      end
      if (move) begin
         out_ff <= exec_out;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff.flags.pf, out_ff.flags.zf, out_ff.flags.sf,
                        out_ff.flags.of, out_ff.flags.cf, out_ff.write_back,
                        out_ff.result};

endmodule
`default_nettype wire

>>> rtl/core/ialu_exec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_exec
// Single-pass datapath: operand masking, operation select and flag update.
// ----------------------------------------------------------------------------
module ialu_exec (
   input  var ialu_pkg::action_type   action,
   input  var ialu_pkg::size_type     size_code,
   input  var logic [63:0]            src_value,
   input  var logic [63:0]            dst_value,
   input  var ialu_pkg::flags_type    flags_cur,
   output     ialu_pkg::exec_out_type exec_out
);
   import ialu_pkg::*;

   logic [DATA_W-1:0] mask;
   logic [DATA_W-1:0] sign;
   logic [DATA_W-1:0] a;
   logic [DATA_W-1:0] b;
   logic [DATA_W:0]   add_sum;
   logic [DATA_W:0]   sub_diff;
   logic [DATA_W-1:0] inc_val;
   logic [DATA_W-1:0] dec_val;
   logic [DATA_W-1:0] neg_val;
   logic [DATA_W-1:0] res_raw;
   logic [DATA_W-1:0] res;
   logic              cf;
   logic              of;
   logic              wb;
   logic              arith;
   logic              a_sgn;
   logic              b_sgn;
   logic              r_sgn;

   always_comb begin
      case (size_code)
         SIZE_BYTE: begin
            mask      = 64'h0000_0000_0000_00FF;
            sign      = 64'h0000_0000_0000_0080;
         end
         SIZE_WORD: begin
            mask      = 64'h0000_0000_0000_FFFF;
            sign      = 64'h0000_0000_0000_8000;
         end
         SIZE_LONG: begin
            mask      = 64'h0000_0000_FFFF_FFFF;
            sign      = 64'h0000_0000_8000_0000;
         end
         SIZE_QUAD: begin
            mask      = 64'hFFFF_FFFF_FFFF_FFFF;
            sign      = 64'h8000_0000_0000_0000;
         end
         default: begin
            mask      = 64'hFFFF_FFFF_FFFF_FFFF;
            sign      = 64'h8000_0000_0000_0000;
         end
      endcase
   end

   assign a        = src_value & mask;
   assign b        = dst_value & mask;
   assign add_sum  = {1'b0, a} + {1'b0, b};
   assign sub_diff = {1'b0, b} - {1'b0, a};
   assign inc_val  = b + 64'd1;
   assign dec_val  = b - 64'd1;
   assign neg_val  = 64'd0 - b;

   always_comb begin
      res_raw = '0;
      cf      = flags_cur.cf;
      wb      = 1'b0;
      arith   = 1'b1;
      case (action)
         ACT_XOR: begin
            res_raw = a ^ b;
            cf      = 1'b0;
            wb      = 1'b1;
         end
         ACT_AND: begin
            res_raw = a & b;
            cf      = 1'b0;
            wb      = 1'b1;
         end
         ACT_TEST: begin
            res_raw = a & b;
            cf      = 1'b0;
         end
         ACT_ADD: begin
            res_raw = add_sum[DATA_W-1:0];
            cf      = |(add_sum[DATA_W:1] & sign);
            wb      = 1'b1;
         end
         ACT_SUB: begin
            res_raw = sub_diff[DATA_W-1:0];
            cf      = sub_diff[DATA_W];
            wb      = 1'b1;
         end
         ACT_CMP: begin
            res_raw = sub_diff[DATA_W-1:0];
            cf      = sub_diff[DATA_W];
         end
         ACT_INC: begin
            res_raw = inc_val;
            wb      = 1'b1;
         end
         ACT_DEC: begin
            res_raw = dec_val;
            wb      = 1'b1;
         end
         ACT_NEG: begin
            res_raw = neg_val;
            cf      = |b;
            wb      = 1'b1;
         end
         default: begin
            arith   = 1'b0;
         end
      endcase
      res = res_raw & mask;
   end

   assign a_sgn = |(a & sign);
   assign b_sgn = |(b & sign);
   assign r_sgn = |(res & sign);

   always_comb begin
      case (action)
         ACT_ADD:          of = (a_sgn == b_sgn) && (a_sgn != r_sgn);
         ACT_SUB, ACT_CMP: of = (a_sgn != b_sgn) && (r_sgn != b_sgn);
         ACT_INC:          of = (res == sign);
         ACT_DEC, ACT_NEG: of = (b == sign);
         default:          of = 1'b0;
      endcase
   end

   always_comb begin
      exec_out.result     = res;
      exec_out.write_back = wb;
      exec_out.flags      = flags_cur;
      if (arith) begin
         exec_out.flags.cf = cf;
         exec_out.flags.of = of;
         exec_out.flags.sf = r_sgn;
         exec_out.flags.zf = ~|res;
         exec_out.flags.pf = ~^res[7:0];
      end else if (action == ACT_STC) begin
         exec_out.flags.cf = 1'b1;
      end
   end

endmodule
`default_nettype wire
